@@ rtl/core/bmmb_pkg.sv @@
// Shared types and constants for the banked memory map bus.
`default_nettype none

package bmmb_pkg;

  localparam int unsigned VRAM_BANK_BYTES = 8192;
  localparam int unsigned WRAM_BANK_BYTES = 4096;
  localparam int unsigned VRAM_BANKS      = 2;
  localparam int unsigned WRAM_BANKS      = 8;

  localparam int unsigned VRAM_DEPTH = VRAM_BANKS * VRAM_BANK_BYTES;
  localparam int unsigned WRAM_DEPTH = WRAM_BANKS * WRAM_BANK_BYTES;
  localparam int unsigned OAM_DEPTH  = 160;
  localparam int unsigned IO_DEPTH   = 128;
  localparam int unsigned HRAM_DEPTH = 127;

  localparam int unsigned VRAM_OFS_W = $clog2(VRAM_BANK_BYTES);
  localparam int unsigned WRAM_OFS_W = $clog2(WRAM_BANK_BYTES);
  localparam int unsigned VBANK_W    = $clog2(VRAM_BANKS);
  localparam int unsigned WBANK_W    = $clog2(WRAM_BANKS);
  localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int unsigned WRAM_AW    = $clog2(WRAM_DEPTH);
  localparam int unsigned OAM_AW     = $clog2(OAM_DEPTH);
  localparam int unsigned IO_AW      = $clog2(IO_DEPTH);
  localparam int unsigned HRAM_AW    = $clog2(HRAM_DEPTH);
  // The clear sweep covers the deepest store.
  localparam int unsigned CLR_AW     = WRAM_AW;

  localparam logic [7:0] UNUSED_READ    = 8'hFF;
  localparam logic [7:0] VBK_READ_MASK  = 8'hFE;
  localparam logic [7:0] SVBK_READ_MASK = 8'hF8;
  localparam logic [WBANK_W-1:0] WBANK_RESET = WBANK_W'(1);

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } bmmb_func_e;

  typedef enum logic [3:0] {
    RGN_CART,
    RGN_VRAM,
    RGN_WRAM,
    RGN_OAM,
    RGN_UNUSED,
    RGN_IF,
    RGN_VBK,
    RGN_SVBK,
    RGN_IO,
    RGN_HRAM,
    RGN_IE
  } bmmb_region_e;

  typedef struct packed {
    logic [0:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  cart_read_data;
  } bmmb_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [0:0]  cart_access;
    logic [0:0]  cart_write_strobe;
    logic [15:0] cart_address;
    logic [7:0]  cart_write_data;
  } bmmb_out_t;

  typedef struct packed {
    bmmb_region_e        region;
    logic [VRAM_AW-1:0]  vram_idx;
    logic [WRAM_AW-1:0]  wram_idx;
    logic [OAM_AW-1:0]   oam_idx;
    logic [IO_AW-1:0]    io_idx;
    logic [HRAM_AW-1:0]  hram_idx;
  } bmmb_dec_t;

  typedef struct packed {
    logic              busy;
    logic [CLR_AW-1:0] addr;
  } bmmb_clr_t;

  typedef struct packed {
    logic         is_write;
    bmmb_region_e region;
    logic [7:0]   imm_data;
    logic         cart_access;
    logic         cart_write_strobe;
    logic [15:0]  cart_address;
    logic [7:0]   cart_write_data;
  } bmmb_s1_t;

endpackage

`default_nettype wire

@@ rtl/core/bmmb_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none

module bmmb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/bmmb_decode.sv @@
// Address decoder: region and per-store index for one bus address.
`default_nettype none

module bmmb_decode (
  input  wire logic [15:0]                  address_i,
  input  wire logic [bmmb_pkg::VBANK_W-1:0] vbank_i,
  input  wire logic [bmmb_pkg::WBANK_W-1:0] wbank_i,
  output      bmmb_pkg::bmmb_dec_t          dec_o
);

  logic [bmmb_pkg::WBANK_W-1:0] wbank_eff;

  // Echo region folds onto work RAM by ignoring bit 13; bit 12 picks the
  // switchable half.
  assign wbank_eff = address_i[bmmb_pkg::WRAM_OFS_W] ? wbank_i : '0;

  always_comb begin
    if (address_i inside {[16'h0000:16'h7FFF], [16'hA000:16'hBFFF]}) begin
      dec_o.region = bmmb_pkg::RGN_CART;
    end else if (address_i inside {[16'h8000:16'h9FFF]}) begin
      dec_o.region = bmmb_pkg::RGN_VRAM;
    end else if (address_i inside {[16'hC000:16'hFDFF]}) begin
      dec_o.region = bmmb_pkg::RGN_WRAM;
    end else if (address_i inside {[16'hFE00:16'hFE9F]}) begin
      dec_o.region = bmmb_pkg::RGN_OAM;
    end else if (address_i inside {[16'hFEA0:16'hFEFF]}) begin
      dec_o.region = bmmb_pkg::RGN_UNUSED;
    end else if (address_i == 16'hFF0F) begin
      dec_o.region = bmmb_pkg::RGN_IF;
    end else if (address_i == 16'hFF4F) begin
      dec_o.region = bmmb_pkg::RGN_VBK;
    end else if (address_i == 16'hFF70) begin
      dec_o.region = bmmb_pkg::RGN_SVBK;
    end else if (address_i inside {[16'hFF00:16'hFF7F]}) begin
      dec_o.region = bmmb_pkg::RGN_IO;
    end else if (address_i inside {[16'hFF80:16'hFFFE]}) begin
      dec_o.region = bmmb_pkg::RGN_HRAM;
    end else begin
      dec_o.region = bmmb_pkg::RGN_IE;
    end

    dec_o.vram_idx = {vbank_i, address_i[bmmb_pkg::VRAM_OFS_W-1:0]};
    dec_o.wram_idx = {wbank_eff, address_i[bmmb_pkg::WRAM_OFS_W-1:0]};
    dec_o.oam_idx  = address_i[bmmb_pkg::OAM_AW-1:0];
    dec_o.io_idx   = address_i[bmmb_pkg::IO_AW-1:0];
    dec_o.hram_idx = address_i[bmmb_pkg::HRAM_AW-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/bmmb_clear.sv @@
// Post-reset sweep that zeroes every RAM store, one address per cycle.
`default_nettype none

module bmmb_clear (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  output      bmmb_pkg::bmmb_clr_t clr_o
);

  logic                        busy_q, busy_d;
  logic [bmmb_pkg::CLR_AW-1:0] addr_q, addr_d;

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      addr_d = addr_q + bmmb_pkg::CLR_AW'(1);
      if (&addr_q) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = addr_q;

endmodule

`default_nettype wire

@@ rtl/core/banked_memory_map_bus.sv @@
// Top level of the banked memory map bus.
`default_nettype none

// Byte-wide memory map of a banked handheld console bus. One read or write
// transfer is accepted per cycle while in_stall_o is low; the accepting edge
// starts the synchronous RAM read and loads stage 1, and the result register
// is loaded from stage 1 once the output register is free or drains. After
// reset the block zeroes all of its RAM stores in a sweep, one address per
// cycle across all stores at once, and holds in_stall_o high until the sweep
// is done. Cartridge ranges are passed out on the result; video and work RAM
// banks are chosen by the VBK and SVBK registers, which take effect for the
// very next transfer.

module banked_memory_map_bus (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire bmmb_pkg::bmmb_in_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      bmmb_pkg::bmmb_out_t out_data_o
);

  bmmb_pkg::bmmb_clr_t clr;
  bmmb_pkg::bmmb_dec_t dec;

  logic                         vbank_q, vbank_d;
  logic [bmmb_pkg::WBANK_W-1:0] wbank_q, wbank_d;
  logic [7:0]                   if_q, if_d;
  logic [7:0]                   ie_q, ie_d;

  logic               s1_valid_q, s1_valid_d;
  bmmb_pkg::bmmb_s1_t s1_q, s1_d;
  logic               out_valid_q, out_valid_d;
  bmmb_pkg::bmmb_out_t out_q, out_d;

  logic in_accept, s1_adv, acc_wr, acc_rd;
  logic [7:0] wdata_mux;

  logic vram_we, vram_re, wram_we, wram_re, oam_we, oam_re;
  logic io_we, io_re, hram_we, hram_re;
  logic [7:0] vram_rd, wram_rd, oam_rd, io_rd, hram_rd;
  logic [7:0] ram_sel_rd;

  bmmb_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  bmmb_decode u_decode (
    .address_i (in_data_i.address),
    .vbank_i   (vbank_q),
    .wbank_i   (wbank_q),
    .dec_o     (dec)
  );

  // Handshake: stage 1 moves on whenever the output register is free or drains.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr.busy || (s1_valid_q && !s1_adv);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign acc_wr     = in_accept && (in_data_i.func == bmmb_pkg::FUNC_WRITE);
  assign acc_rd     = in_accept && (in_data_i.func == bmmb_pkg::FUNC_READ);
  assign wdata_mux  = clr.busy ? 8'h00 : in_data_i.write_data;

  // RAM controls; during the sweep every store is written with zero.
  assign vram_we = clr.busy || (acc_wr && dec.region == bmmb_pkg::RGN_VRAM);
  assign vram_re = acc_rd && dec.region == bmmb_pkg::RGN_VRAM;
  assign wram_we = clr.busy || (acc_wr && dec.region == bmmb_pkg::RGN_WRAM);
  assign wram_re = acc_rd && dec.region == bmmb_pkg::RGN_WRAM;
  assign oam_we  = (clr.busy && clr.addr < bmmb_pkg::CLR_AW'(bmmb_pkg::OAM_DEPTH))
                   || (acc_wr && dec.region == bmmb_pkg::RGN_OAM);
  assign oam_re  = acc_rd && dec.region == bmmb_pkg::RGN_OAM;
  assign io_we   = clr.busy || (acc_wr && dec.region == bmmb_pkg::RGN_IO);
  assign io_re   = acc_rd && dec.region == bmmb_pkg::RGN_IO;
  assign hram_we = (clr.busy && clr.addr < bmmb_pkg::CLR_AW'(bmmb_pkg::HRAM_DEPTH))
                   || (acc_wr && dec.region == bmmb_pkg::RGN_HRAM);
  assign hram_re = acc_rd && dec.region == bmmb_pkg::RGN_HRAM;

  bmmb_ram #(.WIDTH(8), .DEPTH(bmmb_pkg::VRAM_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .re_i    (vram_re),
    .addr_i  (clr.busy ? clr.addr[bmmb_pkg::VRAM_AW-1:0] : dec.vram_idx),
    .wdata_i (wdata_mux),
    .rdata_o (vram_rd)
  );

  bmmb_ram #(.WIDTH(8), .DEPTH(bmmb_pkg::WRAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .re_i    (wram_re),
    .addr_i  (clr.busy ? clr.addr[bmmb_pkg::WRAM_AW-1:0] : dec.wram_idx),
    .wdata_i (wdata_mux),
    .rdata_o (wram_rd)
  );

  bmmb_ram #(.WIDTH(8), .DEPTH(bmmb_pkg::OAM_DEPTH)) u_oam (
    .clk_i   (clk_i),
    .we_i    (oam_we),
    .re_i    (oam_re),
    .addr_i  (clr.busy ? clr.addr[bmmb_pkg::OAM_AW-1:0] : dec.oam_idx),
    .wdata_i (wdata_mux),
    .rdata_o (oam_rd)
  );

  bmmb_ram #(.WIDTH(8), .DEPTH(bmmb_pkg::IO_DEPTH)) u_io (
    .clk_i   (clk_i),
    .we_i    (io_we),
    .re_i    (io_re),
    .addr_i  (clr.busy ? clr.addr[bmmb_pkg::IO_AW-1:0] : dec.io_idx),
    .wdata_i (wdata_mux),
    .rdata_o (io_rd)
  );

  bmmb_ram #(.WIDTH(8), .DEPTH(bmmb_pkg::HRAM_DEPTH)) u_hram (
    .clk_i   (clk_i),
    .we_i    (hram_we),
    .re_i    (hram_re),
    .addr_i  (clr.busy ? clr.addr[bmmb_pkg::HRAM_AW-1:0] : dec.hram_idx),
    .wdata_i (wdata_mux),
    .rdata_o (hram_rd)
  );

  // Control registers.
  always_comb begin
    vbank_d = vbank_q;
    wbank_d = wbank_q;
    if_d    = if_q;
    ie_d    = ie_q;
    if (acc_wr) begin
      case (dec.region)
        bmmb_pkg::RGN_IF:  if_d = in_data_i.write_data;
        bmmb_pkg::RGN_IE:  ie_d = in_data_i.write_data;
        bmmb_pkg::RGN_VBK: vbank_d = in_data_i.write_data[0];
        bmmb_pkg::RGN_SVBK: begin
          // bank 0 is not selectable in the switchable window
          if (in_data_i.write_data[bmmb_pkg::WBANK_W-1:0] == '0) begin
            wbank_d = bmmb_pkg::WBANK_RESET;
          end else begin
            wbank_d = in_data_i.write_data[bmmb_pkg::WBANK_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Stage 1: decoded transfer waiting on the RAM read.
  always_comb begin
    s1_d.is_write          = (in_data_i.func == bmmb_pkg::FUNC_WRITE);
    s1_d.region            = dec.region;
    s1_d.cart_access       = (dec.region == bmmb_pkg::RGN_CART);
    s1_d.cart_write_strobe = s1_d.cart_access && s1_d.is_write;
    s1_d.cart_address      = s1_d.cart_access ? in_data_i.address : 16'h0000;
    s1_d.cart_write_data   = s1_d.cart_write_strobe ? in_data_i.write_data : 8'h00;
    case (dec.region)
      bmmb_pkg::RGN_CART:   s1_d.imm_data = in_data_i.cart_read_data;
      bmmb_pkg::RGN_UNUSED: s1_d.imm_data = bmmb_pkg::UNUSED_READ;
      bmmb_pkg::RGN_IF:     s1_d.imm_data = if_q;
      bmmb_pkg::RGN_IE:     s1_d.imm_data = ie_q;
      bmmb_pkg::RGN_VBK:    s1_d.imm_data = bmmb_pkg::VBK_READ_MASK | {7'h00, vbank_q};
      bmmb_pkg::RGN_SVBK:   s1_d.imm_data = bmmb_pkg::SVBK_READ_MASK
                                            | {{(8 - bmmb_pkg::WBANK_W){1'b0}}, wbank_q};
      default:              s1_d.imm_data = 8'h00;
    endcase
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // Output register.
  always_comb begin
    case (s1_q.region)
      bmmb_pkg::RGN_VRAM: ram_sel_rd = vram_rd;
      bmmb_pkg::RGN_WRAM: ram_sel_rd = wram_rd;
      bmmb_pkg::RGN_OAM:  ram_sel_rd = oam_rd;
      bmmb_pkg::RGN_IO:   ram_sel_rd = io_rd;
      bmmb_pkg::RGN_HRAM: ram_sel_rd = hram_rd;
      default:            ram_sel_rd = s1_q.imm_data;
    endcase
  end

  always_comb begin
    out_d.read_data         = s1_q.is_write ? 8'h00 : ram_sel_rd;
    out_d.cart_access       = s1_q.cart_access;
    out_d.cart_write_strobe = s1_q.cart_write_strobe;
    out_d.cart_address      = s1_q.cart_address;
    out_d.cart_write_data   = s1_q.cart_write_data;
    if (s1_valid_q && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbank_q     <= 1'b0;
      wbank_q     <= bmmb_pkg::WBANK_RESET;
      if_q        <= 8'h00;
      ie_q        <= 8'h00;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vbank_q     <= vbank_d;
      wbank_q     <= wbank_d;
      if_q        <= if_d;
      ie_q        <= ie_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // No transfer is taken while the stores are being zeroed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clr.busy |-> in_stall_o)
    else $error("transfer accepted during clear sweep");

  // The switchable work RAM bank never points at the fixed bank.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wbank_q != '0)
    else $error("work RAM bank select is zero");

  // An accepted transfer always lands in stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> s1_valid_q)
    else $error("accepted transfer lost");

  // A stalled output holds stage 1 in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_q))
    else $error("stage 1 dropped under output stall");

  // Cartridge writes never return read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.cart_write_strobe |-> out_q.read_data == 8'h00)
    else $error("read data on a cartridge write");

endmodule

`default_nettype wire
